/* src/sidt_pkg.sv */
// ----------------------------------------------------------------------------
// sidt_pkg
// Shared types and constants for the security identifier table.
// ----------------------------------------------------------------------------
package sidt_pkg;

    // field widths
    localparam int ID_W   = 32;
    localparam int CTX_W  = 64;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_CTX2ID = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EXISTS   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // register index (paddr bit 2)
    localparam logic REG_UNLABELED  = 1'b0;
    localparam logic REG_ALLOC_STOP = 1'b1;

    localparam logic [ID_W-1:0] ALL_ONES_ID     = '1;
    localparam logic [ID_W-1:0] UNLABELED_RESET = 32'd3;
    localparam logic [ID_W-1:0] NEXT_ID_RESET   = 32'd1;

    // sequencer to scan unit
    typedef struct packed {
        logic start;
        logic run;
        logic key_mode;
        logic wr_en;
    } scan_ctrl_t;

    // scan unit to sequencer
    typedef struct packed {
        logic hit;
        logic miss;
    } scan_stat_t;

endpackage

/* src/sidt_if.sv */
// ----------------------------------------------------------------------------
// sidt_req_if / sidt_rsp_if
// Valid/ready channels carrying request and result words.
// ----------------------------------------------------------------------------
interface sidt_req_if;
    import sidt_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       opcode;
    logic [ID_W-1:0]  sec_id;
    logic [CTX_W-1:0] context_key;

    modport source (output valid, opcode, sec_id, context_key, input ready);
    modport sink (input valid, opcode, sec_id, context_key, output ready);
endinterface

interface sidt_rsp_if;
    import sidt_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [ID_W-1:0]  id_out;
    logic [CTX_W-1:0] context_out;
    logic             used_fallback;

    modport source (output valid, status, id_out, context_out, used_fallback, input ready);
    modport sink (input valid, status, id_out, context_out, used_fallback, output ready);
endinterface

/* src/sidt_scan.sv */
// ----------------------------------------------------------------------------
// sidt_scan
// Entry store with one read port and one write port, a scan address counter
// and the single comparator shared by every lookup.
// ----------------------------------------------------------------------------
module sidt_scan #(
    parameter int ENTRIES  = 64,
    parameter int KEY_BITS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sidt_pkg::scan_ctrl_t                ctrl,
    input  logic [$clog2(ENTRIES+1)-1:0]        count,
    input  logic [sidt_pkg::ID_W-1:0]           target_id,
    input  logic [KEY_BITS-1:0]                 target_key,
    output sidt_pkg::scan_stat_t                stat,
    output logic [sidt_pkg::ID_W-1:0]           rd_id,
    output logic [KEY_BITS-1:0]                 rd_key
);
    import sidt_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int IW = $clog2(ENTRIES);

    logic [ID_W-1:0]     id_mem  [ENTRIES];
    logic [KEY_BITS-1:0] key_mem [ENTRIES];

    logic [CW-1:0]       addr_reg, addr_next;
    logic                pend_reg, pend_next;
    logic [ID_W-1:0]     rd_id_reg;
    logic [KEY_BITS-1:0] rd_key_reg;
    logic                more;
    logic                issue;
    logic                match;

    // read one slot per cycle while filled slots remain
    assign more  = (addr_reg < count);
    assign issue = ctrl.run && !ctrl.start && more;

    always_comb
    begin
        addr_next = addr_reg;
        pend_next = issue;
        if (ctrl.start)
        begin
            addr_next = '0;
        end
        else if (issue)
        begin
            addr_next = addr_reg + 1'b1;
        end
    end

    // shared comparator: identifier or key, against the current target
    assign match = ctrl.key_mode ? (rd_key_reg == target_key) : (rd_id_reg == target_id);

    assign stat.hit  = ctrl.run && pend_reg && match;
    assign stat.miss = ctrl.run && !pend_reg && !more;
    assign rd_id     = rd_id_reg;
    assign rd_key    = rd_key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            addr_reg <= addr_next;
            pend_reg <= pend_next;
        end
    end

    // store: write at the fill point, registered read at the scan address
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            id_mem[count[IW-1:0]]  <= target_id;
            key_mem[count[IW-1:0]] <= target_key;
        end
        if (issue)
        begin
            rd_id_reg  <= id_mem[addr_reg[IW-1:0]];
            rd_key_reg <= key_mem[addr_reg[IW-1:0]];
        end
    end

endmodule

/* src/security_id_table.sv */
// ----------------------------------------------------------------------------
// security_id_table
// Associative table of security identifiers and context keys with an
// identifier allocator, scanned one slot per cycle.
// ----------------------------------------------------------------------------
// Timing: a scan reads each filled slot in turn; its result is registered and then
// loaded into the output register once that is free or being taken (search with
// fallback and allocating context-to-id run two scans; clear runs none).
// Throughput: one word at a time; the next is taken in the cycle after the result
// loads, even while that result waits. Reset: registers to defaults, table
// empty at once (slots fill in order, so the fill count marks the valid ones).
module security_id_table #(
    parameter int ENTRIES  = 64,
    parameter int KEY_BITS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    sidt_req_if.sink                      req,
    sidt_rsp_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sidt_pkg::ADDR_W-1:0]   paddr,
    input  logic [sidt_pkg::DATA_W-1:0]   pwdata,
    output logic [sidt_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import sidt_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INS   = 3'd1;
    localparam logic [2:0] S_SRCH  = 3'd2;
    localparam logic [2:0] S_FALLB = 3'd3;
    localparam logic [2:0] S_CTXK  = 3'd4;
    localparam logic [2:0] S_ALLOC = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [ID_W-1:0]     target_reg, target_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [ID_W-1:0]     next_id_reg, next_id_next;
    logic [ID_W-1:0]     unlabeled_reg;
    logic                stopped_reg;

    logic [1:0]          res_status_reg, res_status_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    logic [KEY_BITS-1:0] res_ctx_reg, res_ctx_next;
    logic                res_fb_reg, res_fb_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_load;
    logic [1:0]          out_status_reg;
    logic [ID_W-1:0]     out_id_reg;
    logic [CTX_W-1:0]    out_ctx_reg;
    logic                out_fb_reg;

    scan_ctrl_t          ctrl;
    scan_stat_t          stat;
    logic [ID_W-1:0]     rd_id;
    logic [KEY_BITS-1:0] rd_key;
    logic                accept;
    logic                full;
    logic                cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_ALLOC_STOP) ? {{(DATA_W-1){1'b0}}, stopped_reg}
                                                 : unlabeled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unlabeled_reg <= UNLABELED_RESET;
            stopped_reg   <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_ALLOC_STOP)
                stopped_reg <= pwdata[0];
            else
                unlabeled_reg <= pwdata;
        end
    end

    // scan unit
    sidt_scan #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .count      (count_reg),
        .target_id  (target_reg),
        .target_key (key_reg),
        .stat       (stat),
        .rd_id      (rd_id),
        .rd_key     (rd_key)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CW'(ENTRIES));

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        target_next     = target_reg;
        key_next        = key_reg;
        count_next      = count_reg;
        next_id_next    = next_id_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_ctx_next    = res_ctx_reg;
        res_fb_next     = res_fb_reg;
        out_load        = 1'b0;
        ctrl            = '0;
        ctrl.run        = (state_reg == S_INS) || (state_reg == S_SRCH) ||
                          (state_reg == S_FALLB) || (state_reg == S_CTXK) ||
                          (state_reg == S_ALLOC);
        ctrl.key_mode   = (state_reg == S_CTXK);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    target_next     = req.sec_id;
                    key_next        = req.context_key[KEY_BITS-1:0];
                    ctrl.start      = 1'b1;
                    res_status_next = ST_OK;
                    res_id_next     = '0;
                    res_ctx_next    = '0;
                    res_fb_next     = 1'b0;
                    case (req.opcode)
                        OP_INSERT: state_next = S_INS;
                        OP_SEARCH: state_next = S_SRCH;
                        OP_CTX2ID: state_next = S_CTXK;
                        default:
                        begin
                            count_next   = '0;
                            next_id_next = NEXT_ID_RESET;
                            state_next   = S_RESP;
                        end
                    endcase
                end
            end
            S_INS, S_ALLOC:
            begin
                if (stat.hit)
                begin
                    res_status_next = ST_EXISTS;
                    state_next      = S_RESP;
                end
                else if (stat.miss)
                begin
                    if (full)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.wr_en  = 1'b1;
                        count_next  = count_reg + 1'b1;
                        res_id_next = target_reg;
                        // a fresh identifier is never all ones, so +1 suffices
                        if (state_reg == S_ALLOC || target_reg >= next_id_reg)
                            next_id_next = target_reg + 1'b1;
                    end
                    state_next = S_RESP;
                end
            end
            S_SRCH, S_FALLB:
            begin
                if (stat.hit)
                begin
                    res_id_next  = rd_id;
                    res_ctx_next = rd_key;
                    res_fb_next  = (state_reg == S_FALLB);
                    state_next   = S_RESP;
                end
                else if (stat.miss)
                begin
                    if (state_reg == S_SRCH)
                    begin
                        target_next = unlabeled_reg;
                        ctrl.start  = 1'b1;
                        state_next  = S_FALLB;
                    end
                    else
                    begin
                        res_status_next = ST_NOTFOUND;
                        state_next      = S_RESP;
                    end
                end
            end
            S_CTXK:
            begin
                if (stat.hit)
                begin
                    res_id_next = rd_id;
                    state_next  = S_RESP;
                end
                else if (stat.miss)
                begin
                    if (next_id_reg == ALL_ONES_ID || stopped_reg)
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        target_next = next_id_reg;
                        ctrl.start  = 1'b1;
                        state_next  = S_ALLOC;
                    end
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            next_id_reg   <= NEXT_ID_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            next_id_reg   <= next_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg     <= target_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_ctx_reg    <= res_ctx_next;
        res_fb_reg     <= res_fb_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_ctx_reg    <= CTX_W'(res_ctx_reg);
            out_fb_reg     <= res_fb_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.id_out        = out_id_reg;
    assign rsp.context_out   = out_ctx_reg;
    assign rsp.used_fallback = out_fb_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ENTRIES))
        else $error("fill count beyond table size");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wr_en |-> !full)
        else $error("store written while full");

    a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wr_en |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("fill count did not follow a store write");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.opcode == OP_CLEAR) |=>
        (count_reg == '0 && next_id_reg == NEXT_ID_RESET))
        else $error("clear did not empty the table");

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for security_id_table. A directed opening covers the
// corner cases: empty search, fallback, duplicates, shared keys, the
// all-ones counter and its wrap, and allocation clashing with an existing
// identifier. Random request words follow over six phases with changing
// registers and flow-control patterns. Every result word is checked against
// a behavioural copy of the table that is kept in the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
    import sidt_pkg::*;

    localparam int TABLE_SLOTS     = 64;
    localparam int PHASES          = 6;
    localparam int WORDS_PER_PHASE = 222;
    localparam int IDLE_LIMIT      = 4000;
    localparam int TAIL_CYCLES     = 160;
    localparam int HOLD_CYCLES     = 400;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  id_out;
        logic [CTX_W-1:0] context_out;
        logic             used_fallback;
    } sid_result_t;

    // table model plus the queue of result words still owed by the block
    class id_table_tracker;
        localparam int SLOTS = TABLE_SLOTS;

        bit             slot_valid [SLOTS];
        bit [ID_W-1:0]  slot_id [SLOTS];
        bit [CTX_W-1:0] slot_ctx [SLOTS];
        int             fill;
        bit [ID_W-1:0]  next_id;
        bit [ID_W-1:0]  unlabeled_id;
        bit             alloc_stop;
        sid_result_t    expected_results [$];
        int             mismatches;
        int             checked;
        int             status_seen [4];
        int             fallbacks;

        function new();
            unlabeled_id = UNLABELED_RESET;
            alloc_stop   = 1'b0;
            empty_table();
        endfunction

        function void empty_table();
            for (int i = 0; i < SLOTS; i++)
                slot_valid[i] = 1'b0;
            fill    = 0;
            next_id = NEXT_ID_RESET;
        endfunction

        function int find_id(bit [ID_W-1:0] id);
            for (int i = 0; i < SLOTS; i++)
                if (slot_valid[i] && slot_id[i] == id)
                    return i;
            return -1;
        endfunction

        function int find_key(bit [CTX_W-1:0] key);
            for (int i = 0; i < SLOTS; i++)
                if (slot_valid[i] && slot_ctx[i] == key)
                    return i;
            return -1;
        endfunction

        // lowest free slot; counter pushed past the identifier
        function bit [1:0] insert_entry(bit [ID_W-1:0] id, bit [CTX_W-1:0] key);
            if (find_id(id) >= 0)
                return ST_EXISTS;
            if (fill >= SLOTS)
                return ST_FULL;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!slot_valid[i])
                begin
                    slot_valid[i] = 1'b1;
                    slot_id[i]    = id;
                    slot_ctx[i]   = key;
                    fill++;
                    if (id >= next_id)
                        next_id = id + 32'd1;
                    return ST_OK;
                end
            end
            return ST_FULL;
        endfunction

        // accepted request word: work out the result it owes
        function void take_request(logic [1:0] op, logic [ID_W-1:0] sid,
                                   logic [CTX_W-1:0] key);
            sid_result_t   r;
            int            slot;
            bit [ID_W-1:0] fresh;
            r = '0;
            case (op)
                OP_INSERT:
                begin
                    r.status = insert_entry(sid, key);
                    if (r.status == ST_OK)
                        r.id_out = sid;
                end
                OP_SEARCH:
                begin
                    slot = find_id(sid);
                    if (slot < 0)
                    begin
                        slot = find_id(unlabeled_id);
                        r.used_fallback = 1'b1;
                    end
                    if (slot < 0)
                    begin
                        r.status        = ST_NOTFOUND;
                        r.used_fallback = 1'b0;
                    end
                    else
                    begin
                        r.id_out      = slot_id[slot];
                        r.context_out = slot_ctx[slot];
                    end
                end
                OP_CTX2ID:
                begin
                    slot = find_key(key);
                    if (slot >= 0)
                        r.id_out = slot_id[slot];
                    else if (next_id == ALL_ONES_ID || alloc_stop)
                        r.status = ST_FULL;
                    else
                    begin
                        // counter stays put if the new identifier cannot go in
                        fresh    = next_id;
                        next_id  = fresh + 32'd1;
                        r.status = insert_entry(fresh, key);
                        if (r.status == ST_OK)
                            r.id_out = fresh;
                        else
                            next_id = fresh;
                    end
                end
                default:
                    empty_table();
            endcase
            expected_results.push_back(r);
        endfunction

        // result word against the oldest expectation
        function void match_result(sid_result_t got);
            sid_result_t want;
            checked++;
            if (expected_results.size() == 0)
            begin
                $error("result word with no request waiting");
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            status_seen[want.status]++;
            if (want.used_fallback)
                fallbacks++;
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.id_out !== want.id_out)
            begin
                $error("id_out: expected %h, got %h", want.id_out, got.id_out);
                mismatches++;
            end
            if (got.context_out !== want.context_out)
            begin
                $error("context_out: expected %h, got %h", want.context_out,
                       got.context_out);
                mismatches++;
            end
            if (got.used_fallback !== want.used_fallback)
            begin
                $error("used_fallback: expected %0d, got %0d", want.used_fallback,
                       got.used_fallback);
                mismatches++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    sidt_req_if req_ch();
    sidt_rsp_if rsp_ch();

    id_table_tracker tracker = new();

    int send_idle_pct;
    int recv_idle_pct;
    bit stall_request;
    int words_sent;
    int reg_writes;

    security_id_table #(
        .ENTRIES  (TABLE_SLOTS),
        .KEY_BITS (CTX_W)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random back-pressure, plus one long hold on request
    initial
    begin
        int hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result monitor
    initial
    begin
        sid_result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                got = {rsp_ch.status, rsp_ch.id_out, rsp_ch.context_out,
                       rsp_ch.used_fallback};
                tracker.match_result(got);
            end
        end
    end

    // watchdog: too long with no word moving on either channel
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** security_id_table: FAILED **");
        $finish;
    end

    // offer one request word, with random gaps, until accepted
    task automatic send_word(logic [1:0] op, logic [ID_W-1:0] sid,
                             logic [CTX_W-1:0] key);
        @(negedge clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= op;
        req_ch.sec_id      <= sid;
        req_ch.context_key <= key;
        do @(posedge clk); while (!req_ch.ready);
        tracker.take_request(op, sid, key);
        words_sent++;
    endtask

    task automatic park_sender();
        @(negedge clk);
        req_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (tracker.expected_results.size() != 0)
            @(posedge clk);
    endtask

    // one APB transfer: setup then access
    task automatic apb_access(logic write, logic reg_sel, logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write a register, read it back, and mirror it in the model
    task automatic set_register(logic reg_sel, logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] readback;
        logic [DATA_W-1:0] ignored;
        logic [DATA_W-1:0] want;
        apb_access(1'b1, reg_sel, value, ignored);
        apb_access(1'b0, reg_sel, '0, readback);
        want = (reg_sel == REG_ALLOC_STOP) ? {31'b0, value[0]} : value;
        if (reg_sel == REG_UNLABELED)
            tracker.unlabeled_id = value;
        else
            tracker.alloc_stop = value[0];
        if (readback !== want)
        begin
            $error("prdata: expected %h, got %h", want, readback);
            tracker.mismatches++;
        end
        reg_writes++;
    endtask

    // identifiers already in the table nearly half the time, so hits and duplicates are common
    function automatic logic [ID_W-1:0] pick_id();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45 && tracker.fill > 0)
            return tracker.slot_id[$urandom_range(tracker.fill - 1)];
        if (roll < 70)
            return $urandom_range(127);
        if (roll < 85)
            return $urandom;
        if (roll < 90)
            return ALL_ONES_ID - $urandom_range(15);
        return tracker.unlabeled_id;
    endfunction

    function automatic logic [CTX_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40 && tracker.fill > 0)
            return tracker.slot_ctx[$urandom_range(tracker.fill - 1)];
        if (roll < 70)
            return CTX_W'($urandom_range(63));
        return {$urandom, $urandom};
    endfunction

    // clears are rare until the table is full, so it gets there and lingers
    function automatic logic [1:0] pick_op();
        int roll;
        if (tracker.fill >= TABLE_SLOTS ? $urandom_range(14) == 0
                                        : $urandom_range(249) == 0)
            return OP_CLEAR;
        roll = $urandom_range(99);
        if (roll < 36)
            return OP_INSERT;
        if (roll < 66)
            return OP_SEARCH;
        return OP_CTX2ID;
    endfunction

    // main sequence
    initial
    begin
        logic [1:0] op;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = OP_INSERT;
        req_ch.sec_id      = '0;
        req_ch.context_key = '0;
        stall_request      = 1'b0;
        send_idle_pct      = 0;
        recv_idle_pct      = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed opening with the reset register values
        send_word(OP_SEARCH, 32'd3, '0);                 // empty table
        send_word(OP_CTX2ID, '0, '0);                    // allocates 1
        send_word(OP_INSERT, 32'd3, '1);
        send_word(OP_INSERT, 32'd3, '0);                 // duplicate
        send_word(OP_SEARCH, ALL_ONES_ID, '0);           // falls back to 3
        send_word(OP_SEARCH, 32'd1, '0);
        send_word(OP_CTX2ID, '0, '1);                    // existing key
        send_word(OP_INSERT, 32'd0, 64'h5555_5555_5555_5555);
        send_word(OP_INSERT, 32'd10, '0);                // key shared with slot 0
        send_word(OP_CTX2ID, '0, '0);                    // lowest slot wins
        send_word(OP_INSERT, ALL_ONES_ID - 1, 64'hAAAA_AAAA_AAAA_AAAA);
        send_word(OP_CTX2ID, '0, 64'h1234);              // counter at all ones
        send_word(OP_INSERT, ALL_ONES_ID, 64'hFFFF_0000_FFFF_0000); // wraps to 0
        send_word(OP_CTX2ID, '0, 64'h42);                // id 0 already there
        send_word(OP_SEARCH, ALL_ONES_ID, '0);
        send_word(OP_CLEAR, ALL_ONES_ID, '1);
        send_word(OP_SEARCH, 32'd3, '0);
        send_word(OP_SEARCH, 32'd0, '0);
        send_word(OP_INSERT, ALL_ONES_ID, '0);
        send_word(OP_CTX2ID, '0, 64'h9);                 // allocates 0
        park_sender();
        drain();

        // random phases: idling pattern changes every two phases
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    send_idle_pct = 24;
                    recv_idle_pct = 65;
                end
                1:
                begin
                    send_idle_pct = 65;
                    recv_idle_pct = 24;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (phase)
                0:       set_register(REG_UNLABELED, UNLABELED_RESET);
                1:       set_register(REG_UNLABELED, ALL_ONES_ID);
                2:       set_register(REG_UNLABELED, '0);
                4:       set_register(REG_UNLABELED, $urandom);
                default: set_register(REG_UNLABELED, $urandom_range(127));
            endcase
            set_register(REG_ALLOC_STOP, phase % 2);
            if (phase == 4)
                stall_request = 1'b1;
            repeat (WORDS_PER_PHASE)
            begin
                op = pick_op();
                send_word(op, pick_id(), pick_key());
            end
            park_sender();
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d request words, %0d result words, %0d register writes.",
                 words_sent, tracker.checked, reg_writes);
        $display("Outcomes ok/exists/full/not-found %0d/%0d/%0d/%0d, fallbacks %0d.",
                 tracker.status_seen[ST_OK], tracker.status_seen[ST_EXISTS],
                 tracker.status_seen[ST_FULL], tracker.status_seen[ST_NOTFOUND],
                 tracker.fallbacks);
        if (tracker.mismatches == 0 && tracker.expected_results.size() == 0)
            $display("** security_id_table: PASSED **");
        else
            $display("** security_id_table: FAILED **");
        $finish;
    end

endmodule
